// File: rtl/frm_pkg.sv
// frm_pkg: shared sizes, constants and types of the frame rate meter and limiter
// depends on nothing; imported by every module of the block
package frm_pkg;

    localparam int WINDOW  = 10;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int TIME_W  = 32;
    localparam int SUM_W   = TIME_W + CNT_W;
    localparam int FPS_W   = 10;
    localparam int RATE_W  = 30;
    localparam int DELAY_W = 10;
    localparam int USED_W  = TIME_W + FPS_W;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam longint NUM_MAX = longint'(WINDOW) * 64'd65536000;
    localparam int NUM_W   = $clog2(NUM_MAX + 1);
    localparam int DCNT_W  = $clog2(NUM_W + 1);

    localparam logic [NUM_W-1:0]  RATE_SCALE = NUM_W'(65536000);
    localparam logic [RATE_W-1:0] RATE_SAT   = RATE_W'(655360000);
    localparam logic [FPS_W-1:0]  FPS_RESET  = FPS_W'(60);
    localparam logic [9:0]        MS_PER_S   = 10'd1000;

    localparam logic [ADDR_W-3:0] REG_MAX_FPS = '0;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_END   = 1'b1;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [SUM_W-1:0]  divisor;
    } frm_div_req_t;

endpackage

// File: rtl/frm_ring_ram.sv
// frm_ring_ram: interval ring storage, one write port and one registered read port
// depends on frm_pkg
module frm_ring_ram
    import frm_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  logic [TIME_W-1:0] wdata,
    input  logic              re,
    input  logic [SLOT_W-1:0] raddr,
    output logic [TIME_W-1:0] rdata
);

    logic [TIME_W-1:0] mem [WINDOW];
    logic [TIME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/frm_div.sv
// frm_div: restoring divider, one quotient bit per cycle, shared by rate and delay
// depends on frm_pkg
module frm_div
    import frm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  frm_div_req_t     req,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [DCNT_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0]  dvd_reg,   dvd_next;
    logic [SUM_W-1:0]  dvsr_reg,  dvsr_next;
    logic [SUM_W-1:0]  rem_reg,   rem_next;
    logic [SUM_W:0]    rem_sh;
    logic              qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvsr_next = dvsr_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, dvd_reg[NUM_W-1]};
        qbit      = (rem_sh >= {1'b0, dvsr_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(NUM_W);
            dvd_next  = req.dividend;
            dvsr_next = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? SUM_W'(rem_sh - {1'b0, dvsr_reg}) : rem_sh[SUM_W-1:0];
            dvd_next = {dvd_reg[NUM_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        dvsr_reg <= dvsr_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;

endmodule

// File: rtl/frame_rate_meter_limiter.sv
// frame_rate_meter_limiter: top level, event sequencer, window state and config port
// depends on frm_pkg, frm_ring_ram, frm_div
//
// Takes millisecond frame start and frame end events. A start event is taken and
// gives no result. An end event gives one result (interval since the last
// end, averaged rate in Q16.16 over the last WINDOW intervals, and whole milliseconds
// still owed under the max_fps cap), computed by one shared bit-per-cycle divider
// that runs up to twice per end event, first for the rate and then for the delay;
// the interval ring is a registered memory read when the event is taken and
// written back in the next cycle. A finished result waits in an output register
// while the next event is taken. max_fps sits at byte address 0 of the register
// port and resets to 60.
module frame_rate_meter_limiter
    import frm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                event_valid,
    output logic                event_ready,
    input  logic                action,
    input  logic [TIME_W-1:0]   now_ms,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [TIME_W-1:0]   frame_interval_ms,
    output logic [RATE_W-1:0]   rate_q16,
    output logic [DELAY_W-1:0]  delay_ms
);

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_UPDATE     = 8'b0000_0010,
        S_PREP       = 8'b0000_0100,
        S_RATE       = 8'b0000_1000,
        S_RATE_WAIT  = 8'b0001_0000,
        S_DELAY      = 8'b0010_0000,
        S_DELAY_WAIT = 8'b0100_0000,
        S_OUT        = 8'b1000_0000
    } frm_state_t;

    frm_state_t         state_reg,    state_next;
    logic [FPS_W-1:0]   max_fps_reg,  max_fps_next;
    logic [TIME_W-1:0]  start_reg,    start_next;
    logic [TIME_W-1:0]  prev_end_reg, prev_end_next;
    logic               seen_end_reg, seen_end_next;
    logic [SLOT_W-1:0]  slot_reg,     slot_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [SUM_W-1:0]   sum_reg,      sum_next;
    logic               out_valid_reg, out_valid_next;

    logic [TIME_W-1:0]  interval_reg, interval_next;
    logic [TIME_W-1:0]  elapsed_reg,  elapsed_next;
    logic [USED_W-1:0]  used_reg,     used_next;
    logic [NUM_W-1:0]   num_reg,      num_next;
    logic [RATE_W-1:0]  rate_reg,     rate_next;
    logic [DELAY_W-1:0] delay_reg,    delay_next;
    logic [TIME_W-1:0]  out_int_reg,  out_int_next;
    logic [RATE_W-1:0]  out_rate_reg, out_rate_next;
    logic [DELAY_W-1:0] out_dly_reg,  out_dly_next;

    logic               in_xfer;
    logic               out_xfer;
    logic               cfg_wr;
    logic               reg_hit;
    logic               full;
    logic               delay_zero;
    logic               ram_we;
    logic [TIME_W-1:0]  ram_rdata;
    frm_div_req_t       div_req;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;

    assign event_ready  = (state_reg == S_IDLE);
    assign in_xfer      = event_valid && event_ready;
    assign out_xfer     = result_valid && result_ready;
    assign reg_hit      = (paddr[ADDR_W-1:2] == REG_MAX_FPS);
    assign cfg_wr       = psel && penable && pwrite && reg_hit;
    assign pready       = 1'b1;
    assign prdata       = reg_hit ? DATA_W'(max_fps_reg) : '0;
    assign full         = (count_reg == CNT_W'(WINDOW));
    assign delay_zero   = (max_fps_reg == '0) || (used_reg >= USED_W'(MS_PER_S));
    assign ram_we       = (state_reg == S_UPDATE);

    frm_ring_ram u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (interval_reg),
        .re    (in_xfer),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = num_reg;
        div_req.divisor  = sum_reg;
        if ((state_reg == S_RATE) && (sum_reg != '0))
        begin
            div_req.start = 1'b1;
        end
        else if ((state_reg == S_DELAY) && !delay_zero)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = NUM_W'(MS_PER_S - used_reg[9:0]);
            div_req.divisor  = SUM_W'(max_fps_reg);
        end
    end

    frm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        max_fps_next   = max_fps_reg;
        start_next     = start_reg;
        prev_end_next  = prev_end_reg;
        seen_end_next  = seen_end_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        interval_next  = interval_reg;
        elapsed_next   = elapsed_reg;
        used_next      = used_reg;
        num_next       = num_reg;
        rate_next      = rate_reg;
        delay_next     = delay_reg;
        out_int_next   = out_int_reg;
        out_rate_next  = out_rate_reg;
        out_dly_next   = out_dly_reg;

        if (cfg_wr)
        begin
            max_fps_next = pwdata[FPS_W-1:0];
        end
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (action == ACT_START)
                    begin
                        start_next = now_ms;
                    end
                    else
                    begin
                        interval_next = seen_end_reg ? (now_ms - prev_end_reg) : '0;
                        elapsed_next  = now_ms - start_reg;
                        prev_end_next = now_ms;
                        seen_end_next = 1'b1;
                        state_next    = S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                if (full)
                begin
                    sum_next = sum_reg - SUM_W'(ram_rdata);
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
                slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                sum_next   = sum_reg + SUM_W'(interval_reg);
                num_next   = NUM_W'(count_reg) * RATE_SCALE;
                used_next  = USED_W'(elapsed_reg) * USED_W'(max_fps_reg);
                state_next = S_RATE;
            end
            S_RATE:
            begin
                if (sum_reg == '0)
                begin
                    rate_next  = RATE_SAT;
                    state_next = S_DELAY;
                end
                else
                begin
                    state_next = S_RATE_WAIT;
                end
            end
            S_RATE_WAIT:
            begin
                if (div_done)
                begin
                    rate_next  = (32'(div_quot) > 32'(RATE_SAT)) ? RATE_SAT
                                                                 : div_quot[RATE_W-1:0];
                    state_next = S_DELAY;
                end
            end
            S_DELAY:
            begin
                if (delay_zero)
                begin
                    delay_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DELAY_WAIT;
                end
            end
            S_DELAY_WAIT:
            begin
                if (div_done)
                begin
                    delay_next = div_quot[DELAY_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_int_next   = interval_reg;
                    out_rate_next  = rate_reg;
                    out_dly_next   = delay_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_fps_reg   <= FPS_RESET;
            start_reg     <= '0;
            prev_end_reg  <= '0;
            seen_end_reg  <= 1'b0;
            slot_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_fps_reg   <= max_fps_next;
            start_reg     <= start_next;
            prev_end_reg  <= prev_end_next;
            seen_end_reg  <= seen_end_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        interval_reg <= interval_next;
        elapsed_reg  <= elapsed_next;
        used_reg     <= used_next;
        num_reg      <= num_next;
        rate_reg     <= rate_next;
        delay_reg    <= delay_next;
        out_int_reg  <= out_int_next;
        out_rate_reg <= out_rate_next;
        out_dly_reg  <= out_dly_next;
    end

    assign result_valid      = out_valid_reg;
    assign frame_interval_ms = out_int_reg;
    assign rate_q16          = out_rate_reg;
    assign delay_ms          = out_dly_reg;

endmodule

// File: rtl/frm_checker.sv
// frm_checker: port-level assertions for the frame rate meter and limiter
// depends on frm_pkg; bound to frame_rate_meter_limiter
module frm_checker
    import frm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                event_valid,
    input  logic                event_ready,
    input  logic                action,
    input  logic                result_valid,
    input  logic                result_ready,
    input  logic [TIME_W-1:0]   frame_interval_ms,
    input  logic [RATE_W-1:0]   rate_q16,
    input  logic [DELAY_W-1:0]  delay_ms
);

    // rate saturates at 10000.0
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (rate_q16 <= RATE_SAT))
    else $error("rate_q16 above saturation");

    // delay never exceeds one second
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (delay_ms <= MS_PER_S))
    else $error("delay_ms above 1000");

    // a start transfer never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && event_ready && (action == ACT_START)) |=> !$rose(result_valid))
    else $error("result after start transfer");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(frame_interval_ms) && $stable(rate_q16)
             && $stable(delay_ms)))
    else $error("stalled result changed");

endmodule

bind frame_rate_meter_limiter frm_checker u_frm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .event_valid       (event_valid),
    .event_ready       (event_ready),
    .action            (action),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .frame_interval_ms (frame_interval_ms),
    .rate_q16          (rate_q16),
    .delay_ms          (delay_ms)
);

// File: dv/testbench.sv
// testbench: self-checking bench for frame_rate_meter_limiter, directed table then random frames
// depends on frm_pkg and frame_rate_meter_limiter; predicts interval, rate and delay per frame end
module testbench;
    import frm_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0]  gap_ms;
        logic [RATE_W-1:0]  rate;
        logic [DELAY_W-1:0] wait_ms;
    } frame_result_t;

    typedef enum logic [1:0] {ROW_EVENT, ROW_WRITE, ROW_READ} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               act;
        logic [31:0]        value;
        logic [ADDR_W-3:0]  reg_idx;
        logic               typed;
        frame_result_t      want;
    } stim_row_t;

    localparam logic [ADDR_W-3:0] REG_SPARE = REG_MAX_FPS + 1'b1;
    localparam frame_result_t NO_RES = '0;
    localparam frame_result_t FIRST_END = '{32'd0, RATE_SAT, 10'd16};
    localparam int SETTLE_CYCLES = 2 * NUM_W + 40;
    localparam int PHASES = 8;
    localparam int FRAMES_PER_PHASE = 200;
    localparam longint RUN_LIMIT = 64'd8_000_000;
    localparam int DIR_ROWS = 35;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_READ,  ACT_START, 32'd60,        REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'd0,         REG_MAX_FPS, 1'b1, FIRST_END},
        '{ROW_EVENT, ACT_END,   32'd0,         REG_MAX_FPS, 1'b1, FIRST_END},
        '{ROW_EVENT, ACT_START, 32'd100,       REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'd110,       REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_START, 32'd1000,      REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'd1016,      REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_START, 32'd2000,      REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'd2017,      REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_START, 32'hFFFF_FFFE, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'h0000_0001, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'hFFFF_FFFF, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_START, 32'h0000_0000, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'hFFFF_FFFF, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_START, 32'h5555_5555, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'hAAAA_AAAA, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_WRITE, ACT_START, 32'd1,         REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_START, 32'hAAAA_AAAA, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'hAAAA_AAAA, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_WRITE, ACT_START, 32'd1000,      REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_START, 32'h1234_5678, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'h1234_5678, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_WRITE, ACT_START, 32'd0,         REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_START, 32'h0000_0010, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'h0000_0010, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_WRITE, ACT_START, 32'hFFFF_FFFF, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_READ,  ACT_START, 32'd1023,      REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_START, 32'h8000_0000, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'h8000_0000, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_WRITE, ACT_START, 32'd7,         REG_SPARE,   1'b0, NO_RES},
        '{ROW_READ,  ACT_START, 32'd1023,      REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_WRITE, ACT_START, 32'hFFFF_FC05, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_READ,  ACT_START, 32'd5,         REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_START, 32'h7FFF_FFFF, REG_MAX_FPS, 1'b0, NO_RES},
        '{ROW_EVENT, ACT_END,   32'h8000_0063, REG_MAX_FPS, 1'b0, NO_RES}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                event_valid = 1'b0;
    logic                event_ready;
    logic                action = ACT_START;
    logic [TIME_W-1:0]   now_ms = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [TIME_W-1:0]   frame_interval_ms;
    logic [RATE_W-1:0]   rate_q16;
    logic [DELAY_W-1:0]  delay_ms;

    // predictor state
    logic [TIME_W-1:0]   start_ms = '0;
    logic [TIME_W-1:0]   last_end_ms = '0;
    logic                end_seen = 1'b0;
    logic [TIME_W-1:0]   gap_hist [WINDOW];
    int                  hist_slot = 0;
    int                  hist_fill = 0;
    logic [63:0]         hist_sum = '0;
    logic [FPS_W-1:0]    cap_fps = FPS_RESET;

    frame_result_t       pending_results [$];
    frame_result_t       head_res;
    int                  stall_pct = 35;
    int                  mismatches = 0;
    int                  results_checked = 0;
    int                  events_sent = 0;
    int                  ends_sent = 0;
    int                  cap_writes = 0;

    frame_rate_meter_limiter DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .event_valid       (event_valid),
        .event_ready       (event_ready),
        .action            (action),
        .now_ms            (now_ms),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .frame_interval_ms (frame_interval_ms),
        .rate_q16          (rate_q16),
        .delay_ms          (delay_ms)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        result_ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s at %0t: expected %0d, got %0d", what, $time, want, got);
    endtask

    task automatic track_frame_event(input logic act, input logic [TIME_W-1:0] t,
                                     output bit produced, output frame_result_t res);
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       quot;
        logic [63:0]       used;
        produced = 1'b0;
        res = NO_RES;
        if (act == ACT_START)
        begin
            start_ms = t;
        end
        else
        begin
            produced = 1'b1;
            gap = end_seen ? t - last_end_ms : '0;
            end_seen = 1'b1;
            last_end_ms = t;
            if (hist_fill == WINDOW)
                hist_sum = hist_sum - 64'(gap_hist[hist_slot]);
            else
                hist_fill++;
            gap_hist[hist_slot] = gap;
            hist_sum = hist_sum + 64'(gap);
            hist_slot = (hist_slot == WINDOW - 1) ? 0 : hist_slot + 1;
            if (hist_sum == 0)
                quot = 64'(RATE_SAT);
            else
                quot = (64'd65536000 * 64'(hist_fill)) / hist_sum;
            if (quot > 64'(RATE_SAT))
                quot = 64'(RATE_SAT);
            elapsed = t - start_ms;
            used = 64'(elapsed) * 64'(cap_fps);
            res.gap_ms = gap;
            res.rate = quot[RATE_W-1:0];
            if (cap_fps == 0 || used >= 64'd1000)
                res.wait_ms = '0;
            else
                res.wait_ms = DELAY_W'((64'd1000 - used) / 64'(cap_fps));
        end
    endtask

    // one transfer per event; called and returns at a falling edge
    task automatic send_event(input logic act, input logic [TIME_W-1:0] t,
                              input logic typed, input frame_result_t want);
        bit            produced;
        frame_result_t res;
        while ($urandom_range(99) < stall_pct)
            @(negedge clk);
        event_valid = 1'b1;
        action = act;
        now_ms = t;
        do @(posedge clk); while (!event_ready);
        track_frame_event(act, t, produced, res);
        if (produced)
        begin
            pending_results.push_back(typed ? want : res);
            ends_sent++;
        end
        events_sent++;
        @(negedge clk);
        event_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-3:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_MAX_FPS)
        begin
            cap_fps = data[FPS_W-1:0];
            cap_writes++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apb_read_check(input logic [ADDR_W-3:0] idx, input logic [31:0] want);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            flag_mismatch("max_fps readback", 64'(want), 64'(prdata));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic run_frames(input int count);
        int          sent;
        int          mode;
        int          frame_len;
        bit          paused;
        logic [31:0] t_ms;
        sent = 0;
        paused = 1'b0;
        frame_len = (cap_fps == 0) ? 20 : 1000 / int'(cap_fps) + 2;
        if ($urandom_range(3) == 0)
            t_ms = 32'hFFFF_FC00 + $urandom_range(1023);
        else
            t_ms = $urandom;
        while (sent < count)
        begin
            if (!paused && sent >= count / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            mode = $urandom_range(99);
            if (mode < 80)
            begin
                // start then end, end lands near the cap boundary
                send_event(ACT_START, t_ms, 1'b0, NO_RES);
                t_ms = t_ms + $urandom_range(frame_len);
                send_event(ACT_END, t_ms, 1'b0, NO_RES);
                t_ms = t_ms + $urandom_range(2);
                sent += 2;
            end
            else if (mode < 88)
            begin
                t_ms = t_ms + $urandom_range(frame_len);
                send_event(ACT_END, t_ms, 1'b0, NO_RES);
                sent++;
            end
            else if (mode < 93)
            begin
                send_event(ACT_START, t_ms, 1'b0, NO_RES);
                t_ms = t_ms + $urandom_range(frame_len);
                sent++;
            end
            else if (mode < 97)
            begin
                // frozen clock fills the window with zero intervals
                repeat (12) send_event(ACT_END, t_ms, 1'b0, NO_RES);
                sent += 12;
            end
            else
            begin
                t_ms = $urandom;
                send_event(logic'($urandom_range(1)), t_ms, 1'b0, NO_RES);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch("result with none pending", 64'd0, 64'(frame_interval_ms));
            end
            else
            begin
                head_res = pending_results.pop_front();
                results_checked++;
                if (frame_interval_ms !== head_res.gap_ms)
                    flag_mismatch("frame_interval_ms", 64'(head_res.gap_ms),
                                  64'(frame_interval_ms));
                if (rate_q16 !== head_res.rate)
                    flag_mismatch("rate_q16", 64'(head_res.rate), 64'(rate_q16));
                if (delay_ms !== head_res.wait_ms)
                    flag_mismatch("delay_ms", 64'(head_res.wait_ms), 64'(delay_ms));
            end
        end
    end

    initial
    begin
        int          p;
        logic [31:0] next_cap;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (dir_rows[r])
        begin
            case (dir_rows[r].kind)
                ROW_WRITE:
                begin
                    wait_idle();
                    apb_write(dir_rows[r].reg_idx, dir_rows[r].value);
                end
                ROW_READ: apb_read_check(dir_rows[r].reg_idx, dir_rows[r].value);
                default: send_event(dir_rows[r].act, dir_rows[r].value,
                                    dir_rows[r].typed, dir_rows[r].want);
            endcase
        end
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: next_cap = 32'd60;
                1: next_cap = 32'd1;
                2: next_cap = 32'd1000;
                3: next_cap = 32'd0;
                4: next_cap = 32'd1023;
                default: next_cap = $urandom_range(1000, 1);
            endcase
            stall_pct = (p == 2) ? 0 : 35;
            wait_idle();
            apb_write(REG_MAX_FPS, next_cap);
            run_frames(FRAMES_PER_PHASE);
        end
        wait_idle();
        $display("sent %0d frame events (%0d frame ends), checked %0d results", events_sent,
                 ends_sent, results_checked);
        $display("cap settings written: %0d, including no cap, 1, 1000 and 1023 fps",
                 cap_writes);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/frm_pkg.sv
rtl/frm_ring_ram.sv
rtl/frm_div.sv
rtl/frame_rate_meter_limiter.sv
rtl/frm_checker.sv
dv/testbench.sv
